// ===== rtl/rhp_pkg.sv =====
// rhp_pkg: shared types, constants and helpers of the record header parser
// depends on: nothing
package rhp_pkg;

  // result kinds
  localparam logic KIND_FIELD  = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // kept low bits of a varint; higher bits only fold into a sticky flag
  localparam int VAL_W = 18;

  // body lengths of serial types 0..6
  localparam logic [3:0] SMALL_LEN [0:6] = '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd6, 4'd8};

  // classified byte handed from the front end to the back end
  typedef struct packed {
    logic              has_hs;    // header size accepted, val holds it
    logic              has_st;    // serial type complete, val/big hold it
    logic              hdr_end;   // header ended cleanly on this byte
    logic              front_bad; // bad header size or open varint at header end
    logic              last;      // final byte of the record
    logic              last_bad;  // length, phase or size fault seen at last byte
    logic [VAL_W-1:0]  val;
    logic              big;       // varint has bits above VAL_W
    logic [15:0]       rlen;
  } rhp_tok_t;

  // body length of a serial type below 2**VAL_W
  function automatic logic [VAL_W-2:0] serial_len(input logic [VAL_W-1:0] st);
    logic [VAL_W-2:0] len;
    if (st <= VAL_W'(6)) begin
      len = (VAL_W-1)'(SMALL_LEN[st[2:0]]);
    end else if (st == VAL_W'(7)) begin
      len = (VAL_W-1)'(8);
    end else if (st <= VAL_W'(11)) begin
      len = '0;
    end else begin
      // (st-12)/2 for even and (st-13)/2 for odd both equal st/2 - 6
      len = st[VAL_W-1:1] - (VAL_W-1)'(6);
    end
    return len;
  endfunction

endpackage

// ===== rtl/rhp_front.sv =====
// rhp_front: accepts record bytes, assembles varints and classifies each byte
// depends on: rhp_pkg
module rhp_front #(
  parameter int MAX_RECORD_BYTES = 65535
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        in_data_byte,
  input  logic [15:0]       in_record_length,
  input  logic              in_last_byte,
  input  logic              q_full,
  output logic              q_push,
  output rhp_pkg::rhp_tok_t q_tok
);
  import rhp_pkg::*;

  localparam logic [1:0] PH_SIZE  = 2'd0;
  localparam logic [1:0] PH_TYPES = 2'd1;
  localparam logic [1:0] PH_SKIP  = 2'd2;

  logic [1:0]       phase_r, phase_nxt;
  logic [VAL_W-1:0] vval_r, vval_nxt;
  logic             vbig_r, vbig_nxt;
  logic [3:0]       vcnt_r, vcnt_nxt;
  logic [15:0]      pos_r, pos_nxt;
  logic [15:0]      hlen_r, hlen_nxt;

  logic             accept;
  logic             in_range;
  logic [VAL_W-1:0] feed_val;
  logic             feed_big;
  logic [3:0]       feed_cnt;
  logic             feed_done;
  logic [16:0]      pos_inc;
  rhp_tok_t         tok;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign in_range = pos_r < in_record_length;
  assign pos_inc  = {1'b0, pos_r} + 17'd1;

  // one varint step
  always_comb begin
    if (vcnt_r >= 4'd8) begin
      feed_val  = {vval_r[VAL_W-9:0], in_data_byte};
      feed_big  = vbig_r || (|vval_r[VAL_W-1:VAL_W-8]);
      feed_cnt  = 4'd9;
      feed_done = 1'b1;
    end else begin
      feed_val  = {vval_r[VAL_W-8:0], in_data_byte[6:0]};
      feed_big  = vbig_r || (|vval_r[VAL_W-1:VAL_W-7]);
      feed_cnt  = vcnt_r + 4'd1;
      feed_done = !in_data_byte[7];
    end
  end

  // classify the byte and work out the next front state
  always_comb begin
    phase_nxt = phase_r;
    vval_nxt  = vval_r;
    vbig_nxt  = vbig_r;
    vcnt_nxt  = vcnt_r;
    hlen_nxt  = hlen_r;
    pos_nxt   = (pos_r != 16'hFFFF) ? pos_inc[15:0] : pos_r;
    tok       = '0;
    tok.rlen  = in_record_length;

    if (in_range && (phase_r == PH_SIZE || phase_r == PH_TYPES)) begin
      vval_nxt = feed_val;
      vbig_nxt = feed_big;
      vcnt_nxt = feed_cnt;
      if (feed_done) begin
        vval_nxt = '0;
        vbig_nxt = 1'b0;
        vcnt_nxt = 4'd0;
        tok.val  = feed_val;
        tok.big  = feed_big;
        if (phase_r == PH_SIZE) begin
          if (feed_big || ({1'b0, feed_val} < {2'b00, pos_inc}) ||
              (feed_val > {2'b00, in_record_length})) begin
            tok.front_bad = 1'b1;
            phase_nxt     = PH_SKIP;
          end else begin
            tok.has_hs = 1'b1;
            hlen_nxt   = feed_val[15:0];
            phase_nxt  = PH_TYPES;
          end
        end else begin
          tok.has_st = 1'b1;
        end
      end
    end

    // header end reached with this byte
    if (phase_nxt == PH_TYPES && in_range && pos_inc == {1'b0, hlen_nxt}) begin
      phase_nxt = PH_SKIP;
      if (vcnt_nxt != 4'd0) begin
        tok.front_bad = 1'b1;
        vval_nxt      = '0;
        vbig_nxt      = 1'b0;
        vcnt_nxt      = 4'd0;
      end else begin
        tok.hdr_end = 1'b1;
      end
    end

    // final byte: status faults known here, then back to the start state
    if (in_last_byte) begin
      tok.last     = 1'b1;
      tok.last_bad = (pos_inc != {1'b0, in_record_length}) || (phase_nxt != PH_SKIP) ||
                     ({16'd0, in_record_length} > 32'(MAX_RECORD_BYTES));
      phase_nxt = PH_SIZE;
      vval_nxt  = '0;
      vbig_nxt  = 1'b0;
      vcnt_nxt  = 4'd0;
      pos_nxt   = 16'd0;
      hlen_nxt  = 16'd0;
    end
  end

  assign q_push = accept && (tok.has_hs || tok.has_st || tok.hdr_end || tok.front_bad ||
                             tok.last);
  assign q_tok  = tok;

  // front state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SIZE;
      vval_r  <= '0;
      vbig_r  <= 1'b0;
      vcnt_r  <= 4'd0;
      pos_r   <= 16'd0;
      hlen_r  <= 16'd0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      vval_r  <= vval_nxt;
      vbig_r  <= vbig_nxt;
      vcnt_r  <= vcnt_nxt;
      pos_r   <= pos_nxt;
      hlen_r  <= hlen_nxt;
    end
  end

  // a varint never holds more than nine bytes
  a_vcnt_bound: assert property (@(posedge clk) disable iff (!rst_n) vcnt_r <= 4'd9)
    else $error("varint byte count out of range");

  // the skip phase never holds a partial varint
  a_skip_clean: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_SKIP |-> vcnt_r == 4'd0)
    else $error("partial varint left in skip phase");

endmodule

// ===== rtl/rhp_tok_fifo.sv =====
// rhp_tok_fifo: two-entry queue of classified bytes between front and back
// depends on: rhp_pkg
module rhp_tok_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  rhp_pkg::rhp_tok_t push_tok,
  output logic              full,
  input  logic              pop,
  output logic              empty,
  output rhp_pkg::rhp_tok_t head_tok
);
  import rhp_pkg::*;

  rhp_tok_t   mem_r [0:1];
  logic       wptr_r, wptr_nxt;
  logic       rptr_r, rptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full     = cnt_r == 2'd2;
  assign empty    = cnt_r == 2'd0;
  assign head_tok = mem_r[rptr_r];

  // pointer and fill count update
  always_comb begin
    wptr_nxt = push ? !wptr_r : wptr_r;
    rptr_nxt = pop ? !rptr_r : rptr_r;
    cnt_nxt  = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_tok;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) !(pop && empty))
    else $error("pop from empty queue");

endmodule

// ===== rtl/rhp_back.sv =====
// rhp_back: tracks body offset and field count, emits descriptors and status
// depends on: rhp_pkg
module rhp_back #(
  parameter int MAX_FIELDS = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  rhp_pkg::rhp_tok_t q_tok,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_result_kind,
  output logic [5:0]        out_field_index,
  output logic [17:0]       out_field_type,
  output logic [15:0]       out_field_offset,
  output logic              out_record_status,
  output logic              out_last_result
);
  import rhp_pkg::*;

  localparam int FC_W = $clog2(MAX_FIELDS + 1);

  logic [15:0]     boff_r, boff_nxt;
  logic [FC_W-1:0] fcnt_r, fcnt_nxt;
  logic            corrupt_r, corrupt_nxt;
  logic            pend_r, pend_nxt;
  logic            pend_status_r, pend_status_nxt;

  logic            out_valid_r, out_valid_nxt;
  logic            kind_r, kind_nxt;
  logic [5:0]      idx_r, idx_nxt;
  logic [17:0]     type_r, type_nxt;
  logic [15:0]     offs_r, offs_nxt;
  logic            status_r, status_nxt;
  logic            lastr_r, lastr_nxt;

  logic              load_ok;
  logic              emit_d;
  logic              emit_s;
  logic              stat_bit;
  logic [VAL_W-2:0]  len;
  logic [VAL_W-1:0]  sum;
  logic [15:0]       boff_w;
  logic              corrupt_w;
  logic [FC_W+5:0]   fcnt_ext;

  assign load_ok  = !out_valid_r || !out_stall;
  assign q_pop    = !q_empty && load_ok && !pend_r;
  assign len      = serial_len(q_tok.val);
  assign fcnt_ext = (FC_W+6)'(fcnt_r);

  // body offset and corruption bookkeeping for one transaction
  always_comb begin
    boff_w    = boff_r;
    corrupt_w = corrupt_r;
    fcnt_nxt  = fcnt_r;
    emit_d    = 1'b0;
    sum       = '0;
    if (q_tok.has_hs) begin
      boff_w = q_tok.val[15:0];
    end
    if (q_tok.front_bad) begin
      corrupt_w = 1'b1;
    end
    if (q_tok.has_st && !corrupt_w) begin
      sum = {2'b00, boff_w} + {1'b0, len};
      if (fcnt_r >= FC_W'(MAX_FIELDS)) begin
        corrupt_w = 1'b1;
      end else if (q_tok.big || sum > {2'b00, q_tok.rlen}) begin
        corrupt_w = 1'b1;
      end else begin
        emit_d   = 1'b1;
        fcnt_nxt = fcnt_r + FC_W'(1);
      end
    end
    // descriptor carries the offset before the add
    boff_nxt = emit_d ? sum[15:0] : boff_w;
    if (q_tok.hdr_end && !corrupt_w && boff_nxt != q_tok.rlen) begin
      corrupt_w = 1'b1;
    end
    emit_s      = q_tok.last;
    stat_bit    = corrupt_w || q_tok.last_bad;
    corrupt_nxt = corrupt_w;
    if (q_tok.last) begin
      boff_nxt    = 16'd0;
      fcnt_nxt    = '0;
      corrupt_nxt = 1'b0;
    end
  end

  // output register and pending status
  always_comb begin
    out_valid_nxt   = out_valid_r;
    kind_nxt        = kind_r;
    idx_nxt         = idx_r;
    type_nxt        = type_r;
    offs_nxt        = offs_r;
    status_nxt      = status_r;
    lastr_nxt       = lastr_r;
    pend_nxt        = pend_r;
    pend_status_nxt = pend_status_r;
    if (load_ok) begin
      out_valid_nxt = 1'b0;
      if (pend_r) begin
        out_valid_nxt = 1'b1;
        kind_nxt      = KIND_STATUS;
        idx_nxt       = 6'd0;
        type_nxt      = 18'd0;
        offs_nxt      = 16'd0;
        status_nxt    = pend_status_r;
        lastr_nxt     = 1'b1;
        pend_nxt      = 1'b0;
      end else if (q_pop && emit_d) begin
        out_valid_nxt   = 1'b1;
        kind_nxt        = KIND_FIELD;
        idx_nxt         = fcnt_ext[5:0];
        type_nxt        = q_tok.val;
        offs_nxt        = boff_w;
        status_nxt      = 1'b0;
        lastr_nxt       = 1'b0;
        pend_nxt        = emit_s;
        pend_status_nxt = stat_bit;
      end else if (q_pop && emit_s) begin
        out_valid_nxt = 1'b1;
        kind_nxt      = KIND_STATUS;
        idx_nxt       = 6'd0;
        type_nxt      = 18'd0;
        offs_nxt      = 16'd0;
        status_nxt    = stat_bit;
        lastr_nxt     = 1'b1;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      boff_r      <= 16'd0;
      fcnt_r      <= '0;
      corrupt_r   <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        boff_r    <= boff_nxt;
        fcnt_r    <= fcnt_nxt;
        corrupt_r <= corrupt_nxt;
      end
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    pend_status_r <= pend_status_nxt;
    kind_r        <= kind_nxt;
    idx_r         <= idx_nxt;
    type_r        <= type_nxt;
    offs_r        <= offs_nxt;
    status_r      <= status_nxt;
    lastr_r       <= lastr_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_result_kind   = kind_r;
  assign out_field_index   = idx_r;
  assign out_field_type    = type_r;
  assign out_field_offset  = offs_r;
  assign out_record_status = status_r;
  assign out_last_result   = lastr_r;

  // a held status always sits behind a descriptor in the output register
  a_pend_behind_field: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> out_valid_r && kind_r == KIND_FIELD)
    else $error("pending status without descriptor ahead");

  a_fcnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fcnt_r <= FC_W'(MAX_FIELDS))
    else $error("field count above limit");

endmodule

// ===== rtl/record_header_parser.sv =====
// record_header_parser: top level, front end, token queue and back end
// depends on: rhp_pkg, rhp_front, rhp_tok_fifo, rhp_back
//
//   channel  direction  handshake             payload
//   in_      input      in_valid / in_stall   data_byte, record_length, last_byte
//   out_     output     out_valid / out_stall result_kind, field_index, field_type,
//                                             field_offset, record_status, last_result
//
// one record byte is taken per cycle unless in_stall is raised; a byte that both
// completes the last serial type and ends the record holds the back end until both results are loaded
// results are registered in the queue and then in the back end's output register
// synchronous active-low reset returns to the start of a record; no clearing pass
// a two-entry queue lets the front end keep taking bytes while a result waits
module record_header_parser #(
  parameter int MAX_FIELDS       = 64,
  parameter int MAX_RECORD_BYTES = 65535
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic [15:0] in_record_length,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_result_kind,
  output logic [5:0]  out_field_index,
  output logic [17:0] out_field_type,
  output logic [15:0] out_field_offset,
  output logic        out_record_status,
  output logic        out_last_result
);
  import rhp_pkg::*;

  logic     q_full;
  logic     q_push;
  logic     q_pop;
  logic     q_empty;
  rhp_tok_t push_tok;
  rhp_tok_t head_tok;

  // byte intake and varint decode
  rhp_front #(
    .MAX_RECORD_BYTES(MAX_RECORD_BYTES)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_byte     (in_data_byte),
    .in_record_length (in_record_length),
    .in_last_byte     (in_last_byte),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_tok            (push_tok)
  );

  // decoupling queue
  rhp_tok_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_tok (push_tok),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head_tok (head_tok)
  );

  // offset tracking and result generation
  rhp_back #(
    .MAX_FIELDS(MAX_FIELDS)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_empty           (q_empty),
    .q_tok             (head_tok),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_result_kind   (out_result_kind),
    .out_field_index   (out_field_index),
    .out_field_type    (out_field_type),
    .out_field_offset  (out_field_offset),
    .out_record_status (out_record_status),
    .out_last_result   (out_last_result)
  );

endmodule

// ===== bench/record_header_parser_test.sv =====
`timescale 1ns / 100ps
// record_header_parser_test: self-checking bench for the record header parser
// depends on: rhp_pkg (result kinds), record_header_parser (unit under test)
module record_header_parser_test;
  import rhp_pkg::*;

  localparam int MAX_FIELDS       = 64;
  localparam int MAX_RECORD_BYTES = 65535;
  localparam int RANDOM_BYTES     = 1200;
  localparam int HOLD_CYCLES      = 250;
  localparam int DRAIN_CYCLES     = 20;
  localparam int CYCLE_LIMIT      = 1000000;
  localparam int REPORT_LIMIT     = 10;

  typedef enum logic [1:0] {PH_HDR_SIZE, PH_SERIAL_TYPES, PH_SKIP_BODY} parse_phase_t;

  typedef struct packed {
    logic        kind;
    logic [5:0]  index;
    logic [17:0] stype;
    logic [15:0] offset;
    logic        corrupt;
    logic        last;
  } header_result_t;

  logic        clk              = 1'b0;
  logic        rst_n            = 1'b0;
  logic        in_valid         = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte     = 8'h00;
  logic [15:0] in_record_length = 16'd1;
  logic        in_last_byte     = 1'b0;
  logic        out_valid;
  logic        out_stall        = 1'b0;
  logic        out_result_kind;
  logic [5:0]  out_field_index;
  logic [17:0] out_field_type;
  logic [15:0] out_field_offset;
  logic        out_record_status;
  logic        out_last_result;

  // header parse state tracked alongside the block
  parse_phase_t hdr_phase;
  logic [63:0]  acc_value;
  int unsigned  acc_bytes;
  logic [31:0]  rec_pos;
  logic [31:0]  hdr_size;
  logic [31:0]  body_pos;
  int unsigned  n_fields;
  logic         is_corrupt;

  header_result_t expected_results[$];
  logic [7:0]     rec_bytes[$];
  header_result_t seen_result;
  header_result_t want_result;

  // traffic shaping shared with the receiver process
  int sender_gap_rate  = 2;
  bit receiver_stalls  = 1'b1;
  int hold_ticket      = 0;
  int hold_served      = 0;
  int stall_left       = 0;

  int cycle_count      = 0;
  int mismatch_count   = 0;
  int bytes_sent       = 0;
  int records_sent     = 0;
  int fields_checked   = 0;
  int clean_records    = 0;
  int corrupt_records  = 0;

  record_header_parser #(
    .MAX_FIELDS(MAX_FIELDS),
    .MAX_RECORD_BYTES(MAX_RECORD_BYTES)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data_byte(in_data_byte),
    .in_record_length(in_record_length),
    .in_last_byte(in_last_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_result_kind(out_result_kind),
    .out_field_index(out_field_index),
    .out_field_type(out_field_type),
    .out_field_offset(out_field_offset),
    .out_record_status(out_record_status),
    .out_last_result(out_last_result)
  );

  always #5 clk = ~clk;

  // body length of a serial type
  function automatic logic [63:0] serial_body_len(input logic [63:0] st);
    logic [63:0] len;
    case (st)
      64'd0, 64'd8, 64'd9, 64'd10, 64'd11: len = 64'd0;
      64'd1, 64'd2, 64'd3, 64'd4: len = st;
      64'd5: len = 64'd6;
      64'd6, 64'd7: len = 64'd8;
      default: len = st[0] ? (st - 64'd13) >> 1 : (st - 64'd12) >> 1;
    endcase
    return len;
  endfunction

  function automatic void clear_parse_state();
    hdr_phase  = PH_HDR_SIZE;
    acc_value  = '0;
    acc_bytes  = 0;
    rec_pos    = '0;
    hdr_size   = '0;
    body_pos   = '0;
    n_fields   = 0;
    is_corrupt = 1'b0;
  endfunction

  function automatic void mark_corrupt();
    is_corrupt = 1'b1;
    hdr_phase  = PH_SKIP_BODY;
  endfunction

  // shift one byte into the varint; the ninth byte brings all 8 bits and ends it
  function automatic bit take_varint_byte(input logic [7:0] b);
    if (acc_bytes >= 8) begin
      acc_value = {acc_value[55:0], b};
      acc_bytes = 9;
      return 1'b1;
    end
    acc_value = {acc_value[56:0], b[6:0]};
    acc_bytes++;
    return !b[7];
  endfunction

  // expected results of one accepted input transaction
  function automatic void predict_byte(input logic [7:0] b, input logic [15:0] rl,
                                       input logic lst);
    logic [31:0]    pos;
    logic [63:0]    value;
    logic [63:0]    len;
    logic           bad;
    header_result_t r;
    pos = rec_pos;
    if (pos < 32'(rl)) begin
      if (hdr_phase == PH_HDR_SIZE) begin
        if (take_varint_byte(b)) begin
          value     = acc_value;
          acc_value = '0;
          acc_bytes = 0;
          if (value < 64'(pos) + 64'd1 || value > 64'(rl)) begin
            mark_corrupt();
          end else begin
            hdr_size  = value[31:0];
            body_pos  = value[31:0];
            hdr_phase = PH_SERIAL_TYPES;
          end
        end
      end else if (hdr_phase == PH_SERIAL_TYPES) begin
        if (take_varint_byte(b)) begin
          value     = acc_value;
          len       = serial_body_len(value);
          acc_value = '0;
          acc_bytes = 0;
          if (n_fields >= MAX_FIELDS) begin
            mark_corrupt();
          end else if (64'(body_pos) + len > 64'(rl)) begin
            mark_corrupt();
          end else begin
            r = '{kind: KIND_FIELD, index: 6'(n_fields), stype: value[17:0],
                  offset: body_pos[15:0], corrupt: 1'b0, last: 1'b0};
            expected_results.push_back(r);
            body_pos = body_pos + len[31:0];
            n_fields++;
          end
        end
      end
    end

    // header ends on this byte
    if (hdr_phase == PH_SERIAL_TYPES && pos < 32'(rl) && pos + 32'd1 == hdr_size) begin
      if (acc_bytes != 0 || body_pos != 32'(rl)) begin
        mark_corrupt();
      end else begin
        hdr_phase = PH_SKIP_BODY;
      end
    end

    if (rec_pos < 32'hffff) rec_pos++;

    // final status, then back to the start of a record
    if (lst) begin
      bad = is_corrupt || (pos + 32'd1 != 32'(rl)) || hdr_phase != PH_SKIP_BODY ||
            32'(rl) > MAX_RECORD_BYTES;
      r = '{kind: KIND_STATUS, index: '0, stype: '0, offset: '0, corrupt: bad, last: 1'b1};
      expected_results.push_back(r);
      clear_parse_state();
    end
  endfunction

  function automatic string result_text(input header_result_t r);
    return $sformatf("kind=%0d index=%0d type=%0d offset=%0d corrupt=%0d last=%0d",
                     r.kind, r.index, r.stype, r.offset, r.corrupt, r.last);
  endfunction

  // one input transaction, with an occasional idle burst in front
  task automatic send_byte(input logic [7:0] b, input logic [15:0] rl, input logic lst);
    if (sender_gap_rate != 0 && $urandom_range(0, 7) < sender_gap_rate) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_data_byte     <= b;
    in_record_length <= rl;
    in_last_byte     <= lst;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_byte(b, rl, lst);
    bytes_sent++;
  endtask

  task automatic send_record(input logic [15:0] rl);
    foreach (rec_bytes[i]) send_byte(rec_bytes[i], rl, i == rec_bytes.size() - 1);
    records_sent++;
  endtask

  // sender goes quiet until every outstanding result has been checked
  task automatic pause_until_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic append_varint(input logic [63:0] v);
    int groups;
    groups = 1;
    if (v[63:56] != 8'h00) begin
      // nine-byte form: 8 groups of 7 bits, then a full byte
      for (int i = 7; i >= 0; i--) rec_bytes.push_back(8'h80 | 8'((v >> (8 + 7 * i)) & 64'h7f));
      rec_bytes.push_back(v[7:0]);
    end else begin
      while (groups < 8 && (v >> (7 * groups)) != 0) groups++;
      for (int i = groups - 1; i >= 0; i--)
        rec_bytes.push_back(8'((v >> (7 * i)) & 64'h7f) | (i != 0 ? 8'h80 : 8'h00));
    end
  endtask

  // well-formed record of nf fields; a field at huge_at gets an oversize type
  task automatic build_record(input int nf, input int cap, input int huge_at,
                              output logic [15:0] rl);
    logic [63:0] st;
    logic [7:0]  type_bytes[$];
    int          body;
    int          hs;
    int          pick;
    body = 0;
    rec_bytes.delete();
    for (int f = 0; f < nf; f++) begin
      pick = $urandom_range(0, 39);
      if (nf > 16) begin
        st = (pick % 5 == 0) ? 64'd0 : 64'($urandom_range(8, 11));
      end else if (pick < 24) begin
        st = 64'($urandom_range(0, 11));
      end else if (pick < 39) begin
        st = 64'(12 + $urandom_range(0, 2 * cap + 1));
      end else begin
        st = 64'($urandom_range(12, 700));
      end
      if (f == huge_at) begin
        st = {$urandom, $urandom};
      end else begin
        body += int'(serial_body_len(st));
      end
      append_varint(st);
    end
    type_bytes = rec_bytes;
    hs = type_bytes.size() + 1;
    if (hs > 127) hs++;
    rec_bytes.delete();
    append_varint(64'(hs));
    foreach (type_bytes[i]) rec_bytes.push_back(type_bytes[i]);
    repeat (body) rec_bytes.push_back(8'($urandom_range(0, 255)));
    rl = 16'(hs + body);
  endtask

  // receiver: random stall bursts plus a long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (hold_served != hold_ticket) begin
      hold_served <= hold_ticket;
      stall_left  <= HOLD_CYCLES - 1;
      out_stall   <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if (receiver_stalls && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 15);
      out_stall  <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // result check against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      seen_result = '{kind: out_result_kind, index: out_field_index, stype: out_field_type,
                      offset: out_field_offset, corrupt: out_record_status,
                      last: out_last_result};
      if (seen_result.kind === KIND_FIELD) fields_checked++;
      else if (seen_result.corrupt === 1'b1) corrupt_records++;
      else clean_records++;
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("%0t: result with nothing pending: %s", $time, result_text(seen_result));
      end else begin
        want_result = expected_results.pop_front();
        if (seen_result.kind !== want_result.kind || seen_result.index !== want_result.index ||
            seen_result.stype !== want_result.stype ||
            seen_result.offset !== want_result.offset ||
            seen_result.corrupt !== want_result.corrupt ||
            seen_result.last !== want_result.last) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT) begin
            $display("%0t: wrong result", $time);
            $display("  got      %s", result_text(seen_result));
            $display("  expected %s", result_text(want_result));
          end
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count,
               expected_results.size());
      $display("Mismatches found");
      $finish;
    end
  end

  // short records: clean minimal ones and one for each way a header can go wrong
  task automatic test_edge_records();
    // smallest clean record: header size only
    rec_bytes = '{8'h01};
    send_record(16'd1);
    // header size smaller than its own varint
    rec_bytes = '{8'h00};
    send_record(16'd1);
    // all-ones bytes and length, header size far beyond the record
    rec_bytes = '{8'hff, 8'hff, 8'h7f};
    send_record(16'hffff);
    // header size larger than record length
    rec_bytes = '{8'h05, 8'h00};
    send_record(16'd2);
    // serial type varint still open at header end
    rec_bytes = '{8'h02, 8'h81};
    send_record(16'd2);
    // field body running past the record
    rec_bytes = '{8'h02, 8'h01};
    send_record(16'd2);
    // body shorter than the record length
    rec_bytes = '{8'h02, 8'h00, 8'h00};
    send_record(16'd3);
    // header end on the last byte: descriptor and status from one transaction
    rec_bytes = '{8'h02, 8'h0a};
    send_record(16'd2);
    // last byte flagged before the record length is reached
    rec_bytes = '{8'h02, 8'h01};
    send_record(16'd3);
    // bytes past the record length are dropped, length still wrong
    rec_bytes = '{8'h02, 8'h0b, 8'haa};
    send_record(16'd2);
    // nine-byte header size varint
    rec_bytes.delete();
    repeat (8) rec_bytes.push_back(8'h80);
    rec_bytes.push_back(8'h0a);
    rec_bytes.push_back(8'h00);
    send_record(16'd10);
  endtask

  // full field count, then one field too many
  task automatic test_field_limit();
    rec_bytes.delete();
    rec_bytes.push_back(8'(MAX_FIELDS + 1));
    repeat (MAX_FIELDS) rec_bytes.push_back(8'h00);
    send_record(16'(MAX_FIELDS + 1));
    rec_bytes.delete();
    rec_bytes.push_back(8'(MAX_FIELDS + 2));
    repeat (MAX_FIELDS + 1) rec_bytes.push_back(8'h00);
    send_record(16'(MAX_FIELDS + 2));
  endtask

  // offsets above 32767 from a large blob, record cut short
  task automatic test_wide_offsets();
    rec_bytes.delete();
    rec_bytes.push_back(8'h05);
    append_varint(64'd80012);
    rec_bytes.push_back(8'h00);
    rec_bytes.push_back(8'h5a);
    send_record(16'd40005);
  endtask

  // receiver holds off while the sender keeps offering, then a mid-record pause
  task automatic test_backpressure();
    logic [15:0] rl;
    sender_gap_rate = 0;
    hold_ticket <= hold_ticket + 1;
    repeat (8) begin
      build_record($urandom_range(1, 6), 3, -1, rl);
      send_record(rl);
    end
    pause_until_drained();
    build_record(6, 2, -1, rl);
    for (int i = 0; i < rec_bytes.size(); i++) begin
      if (i == rec_bytes.size() / 2) pause_until_drained();
      send_byte(rec_bytes[i], rl, i == rec_bytes.size() - 1);
    end
    records_sent++;
  endtask

  // mostly well-formed records, some damaged ones and some noise
  task automatic test_random_records();
    logic [15:0] rl;
    logic [7:0]  b;
    int          first;
    int          shape;
    int          nf;
    int          adj;
    first = bytes_sent;
    while (bytes_sent < first + RANDOM_BYTES) begin
      sender_gap_rate = $urandom_range(0, 3);
      receiver_stalls <= ($urandom_range(0, 3) != 0);
      shape = $urandom_range(0, 19);
      nf = ($urandom_range(0, 19) == 0) ? $urandom_range(17, 66) : $urandom_range(0, 8);
      if (shape < 15) begin
        build_record(nf, $urandom_range(0, 10), -1, rl);
      end else if (shape < 18) begin
        build_record(nf, $urandom_range(0, 6),
                     ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 8)) : -1, rl);
        case ($urandom_range(0, 3))
          0: rec_bytes[$urandom_range(0, rec_bytes.size() - 1)] = 8'($urandom_range(0, 255));
          1: begin
            if (rec_bytes.size() > 1)
              repeat ($urandom_range(1, rec_bytes.size() - 1)) void'(rec_bytes.pop_back());
          end
          2: repeat ($urandom_range(1, 4)) rec_bytes.push_back(8'($urandom_range(0, 255)));
          default: begin
            adj = int'(rl) + int'($urandom_range(0, 6)) - 3;
            if (adj < 1) adj = 1;
            rl = 16'(adj);
          end
        endcase
      end else begin
        rec_bytes.delete();
        repeat ($urandom_range(1, 12)) begin
          b = 8'($urandom_range(0, 255));
          if ($urandom_range(0, 1) == 1) b[7] = 1'b1;
          rec_bytes.push_back(b);
        end
        rl = ($urandom_range(0, 1) == 1) ? 16'($urandom_range(1, 16)) :
                                           16'($urandom_range(1, 65535));
      end
      send_record(rl);
      if ($urandom_range(0, 14) == 0) pause_until_drained();
    end
  endtask

  // closing stretch at full rate on both sides
  task automatic test_streaming();
    logic [15:0] rl;
    sender_gap_rate = 0;
    receiver_stalls <= 1'b0;
    repeat (10) begin
      build_record($urandom_range(0, 8), $urandom_range(0, 6), -1, rl);
      send_record(rl);
    end
  endtask

  initial begin
    clear_parse_state();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_edge_records();
    test_field_limit();
    test_wide_offsets();
    test_backpressure();
    test_random_records();
    test_streaming();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("run covered %0d records in %0d bytes, with random gaps, stalls and a long hold-off",
             records_sent, bytes_sent);
    $display("checked %0d field descriptors, %0d clean and %0d corrupt record statuses",
             fields_checked, clean_records, corrupt_records);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
